// ----- src/bbe_pkg.sv -----
// ---------------------------------------------------------------------------
// bbe_pkg
// Types, register indexes and saturating helpers for the b-spline basis core.
// ---------------------------------------------------------------------------
package bbe_pkg;

    localparam int ORDER_CAP_DEF  = 8;
    localparam int KNOT_DEPTH_DEF = 64;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // configuration register indexes
    localparam logic CFG_ORDER = 1'b0;
    localparam logic CFG_BDIM  = 1'b1;

    localparam logic [3:0] ORDER_RST = 4'd4;
    localparam logic [5:0] BDIM_RST  = 6'd4;

    // input word
    typedef struct packed {
        logic               cmd;
        logic [5:0]         knot_index;
        logic signed [31:0] knot_value;
        logic signed [31:0] param_x;
        logic [3:0]         deriv_order;
        logic               left_continuous;
    } t_in;

    // result word
    typedef struct packed {
        logic [5:0]         base_index;
        logic [2:0]         coef_slot;
        logic signed [63:0] coef_value;
        logic               last;
        logic               fault;
    } t_out;

    // saturated value with overflow flag
    typedef struct packed {
        logic               flt;
        logic signed [63:0] val;
    } t_sat;

    // result of a shared arithmetic unit
    typedef struct packed {
        logic               done;
        logic               flt;
        logic signed [63:0] val;
    } t_ures;

    // magnitude of a signed 64-bit value, exact for the most negative one
    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        mag64 = v[63] ? (64'd0 - v) : v;
    endfunction

    // signed result from sign and magnitude, saturated to 64 bits
    function automatic t_sat sat_pack(input logic neg, input logic hi_nz,
                                      input logic [63:0] lo);
        t_sat       r;
        logic [63:0] lim;
        logic [63:0] m;
        lim   = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        m     = lo;
        r.flt = 1'b0;
        if (hi_nz || (lo > lim)) begin
            r.flt = 1'b1;
            m     = lim;
        end
        r.val = neg ? (64'd0 - m) : m;
        if (!hi_nz && (lo == 64'd0)) begin
            r.val = 64'sd0;
        end
        sat_pack = r;
    endfunction

    // saturating add or subtract, a + b or a - b
    function automatic t_sat sat_add(input logic signed [63:0] a,
                                     input logic signed [63:0] b, input logic sub);
        t_sat               r;
        logic signed [64:0] bx;
        logic signed [64:0] s;
        bx = {b[63], b};
        if (sub) begin
            bx = 65'sd0 - bx;
        end
        s     = {a[63], a} + bx;
        r.flt = s[64] != s[63];
        r.val = s[63:0];
        if (r.flt) begin
            r.val = s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        sat_add = r;
    endfunction

endpackage

// ----- src/bspline_basis_eval_core.sv -----
// ---------------------------------------------------------------------------
// bspline_basis_eval_core
// B-spline basis and derivative coefficients by the Cox-de Boor recursion.
// ---------------------------------------------------------------------------
//  channel   | signals                           | direction
//  ----------+-----------------------------------+----------
//  command   | start, i_in / busy                | in / out
//  result    | o_strobe, o_res                   | out
//  config    | i_cfg_we, i_cfg_idx, i_cfg_data   | in
//
// A knot load completes in the accepting cycle. An evaluate word walks the
// knots, steps the span down over knots equal to x, then runs the k*(k-1)/2
// recursion steps (none when deriv_order >= k), each through the shared divider
// and, on non-derivative levels, two products on the shared multiplier, then k result words.
// Synchronous active-low reset; the knot table holds no reset value.
// Results come once per cycle in a burst and cannot be stalled.
module bspline_basis_eval_core #(
    parameter int ORDER_CAP  = bbe_pkg::ORDER_CAP_DEF,
    parameter int KNOT_DEPTH = bbe_pkg::KNOT_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  bbe_pkg::t_in  i_in,
    output logic          o_strobe,
    output bbe_pkg::t_out o_res,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [5:0]    i_cfg_data
);
    import bbe_pkg::*;

    localparam int AW  = $clog2(KNOT_DEPTH);
    localparam int IW  = $clog2(ORDER_CAP + 64 + 2);
    localparam int JW  = $clog2(ORDER_CAP + 1);
    localparam int AIW = (ORDER_CAP > 1) ? $clog2(ORDER_CAP) : 1;
    localparam int MW  = (ORDER_CAP > 1) ? $clog2(ORDER_CAP) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN, S_FIX, S_LRD, S_LCHK, S_CLAMP, S_JSEL, S_JRD1, S_JRD2,
        S_JCAP, S_ARD1, S_ARD2, S_ADEN, S_ADIV, S_AM1S, S_AM1, S_AM2S, S_AM2,
        S_EMIT
    } t_state;

    t_state             r_state;
    logic [3:0]         r_order;
    logic [5:0]         r_bdim;
    logic [JW-1:0]      r_k;
    logic [IW-1:0]      r_b;
    logic [IW-1:0]      r_n;
    logic signed [31:0] r_x;
    logic               r_left;
    logic [3:0]         r_nd;
    logic [IW-1:0]      r_i;
    logic [IW-1:0]      r_c;
    logic               r_pv;
    logic [IW-1:0]      r_m;
    logic               r_mval;
    logic [IW-1:0]      r_first;
    logic               r_firstf;
    logic [IW-1:0]      r_last;
    logic signed [31:0] r_tprev;
    logic signed [31:0] r_tb;
    logic [IW-1:0]      r_mu;
    logic [JW-1:0]      r_j;
    logic [JW-1:0]      r_a;
    logic               r_pos;
    logic signed [31:0] r_ta;
    logic signed [63:0] r_term;
    logic signed [63:0] r_p1;
    logic signed [63:0] r_saved;
    logic               r_flt;
    logic signed [63:0] r_coef [ORDER_CAP];
    logic signed [32:0] r_dr   [ORDER_CAP];
    logic signed [32:0] r_dl   [ORDER_CAP];
    logic               r_strobe;
    t_out               r_res;

    logic [JW-1:0]      c_k;
    logic [IW-1:0]      c_b;
    logic [IW-1:0]      c_km1;
    logic [IW-1:0]      c_bm1;
    logic [IW-1:0]      c_m1;
    logic [IW-1:0]      c_mu;
    logic [IW-1:0]      c_ridx;
    logic [AIW-1:0]     c_ai;
    logic [AIW-1:0]     c_dli;
    logic               c_alast;
    logic               c_load;
    logic               c_eval;
    logic signed [31:0] c_t;
    logic [31:0]        rd_data;
    logic               div_start;
    logic signed [32:0] div_den;
    logic [MW-1:0]      div_mult;
    t_ures              div_res;
    logic               mul_start;
    logic signed [32:0] mul_delta;
    t_ures              mul_res;
    t_sat               c_sub;
    t_sat               c_add;

    // order and bdim as used
    always_comb begin
        c_k = JW'(r_order);
        if (r_order == 4'd0) begin
            c_k = JW'(1);
        end else if (32'(r_order) > ORDER_CAP) begin
            c_k = JW'(ORDER_CAP);
        end
        c_b = (IW'(r_bdim) < IW'(c_k)) ? IW'(c_k) : IW'(r_bdim);
    end

    // span clamp to k-1 .. b-1, with b the bdim as used
    assign c_km1 = IW'(r_k) - IW'(1);
    assign c_bm1 = r_b - IW'(1);
    assign c_m1  = (r_m < c_km1) ? c_km1 : r_m;
    assign c_mu  = (c_m1 > c_bm1) ? c_bm1 : c_m1;

    assign c_ai    = r_a[AIW-1:0];
    assign c_dli   = AIW'(r_j - JW'(1) - r_a);
    assign c_alast = (r_a + JW'(1)) == r_j;
    assign c_t     = $signed(rd_data);
    assign c_load  = start && !busy && (i_in.cmd == CMD_LOAD);
    assign c_eval  = start && !busy && (i_in.cmd == CMD_EVAL);

    // knot read address
    always_comb begin
        case (r_state)
            S_SCAN:  c_ridx = r_i;
            S_LRD:   c_ridx = r_m;
            S_JRD1:  c_ridx = r_mu + IW'(r_j);
            S_JRD2:  c_ridx = r_mu + IW'(1) - IW'(r_j);
            S_ARD1:  c_ridx = r_mu + IW'(1) + IW'(r_a);
            S_ARD2:  c_ridx = r_mu + IW'(1) - IW'(r_j) + IW'(r_a);
            default: c_ridx = '0;
        endcase
    end

    bbe_ram #(.WIDTH(32), .DEPTH(KNOT_DEPTH)) u_knots (
        .i_clk   (i_clk),
        .i_we    (c_load),
        .i_waddr (AW'(i_in.knot_index)),
        .i_wdata (i_in.knot_value),
        .i_raddr (AW'(c_ridx)),
        .o_rdata (rd_data)
    );

    // shared divider
    assign div_start = r_state == S_ADEN;
    assign div_den   = {r_ta[31], r_ta} - {c_t[31], c_t};
    assign div_mult  = r_pos ? MW'(1) : MW'(r_j);

    bbe_div #(.ORDER_CAP(ORDER_CAP)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_coef[c_ai]),
        .i_mult  (div_mult),
        .i_den   (div_den),
        .o_res   (div_res)
    );

    // shared multiplier
    assign mul_start = (r_state == S_AM1S) || (r_state == S_AM2S);
    assign mul_delta = (r_state == S_AM1S) ? r_dr[c_ai] : r_dl[c_dli];

    bbe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_delta (mul_delta),
        .i_term  (r_term),
        .o_res   (mul_res)
    );

    assign c_sub = sat_add(r_saved, div_res.val, 1'b1);
    assign c_add = sat_add(r_saved, r_p1, 1'b0);

    // sequencer, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_order  <= ORDER_RST;
            r_bdim   <= BDIM_RST;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ORDER: r_order <= i_cfg_data[3:0];
                    CFG_BDIM:  r_bdim  <= i_cfg_data;
                    default:   r_bdim  <= r_bdim;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (c_eval) begin
                        r_x      <= i_in.param_x;
                        r_left   <= i_in.left_continuous;
                        r_nd     <= i_in.deriv_order;
                        r_k      <= c_k;
                        r_b      <= c_b;
                        r_n      <= IW'(c_k) + c_b;
                        r_i      <= '0;
                        r_pv     <= 1'b0;
                        r_mval   <= 1'b0;
                        r_first  <= IW'(c_k) + c_b - IW'(1);
                        r_firstf <= 1'b0;
                        r_last   <= '0;
                        r_flt    <= 1'b0;
                        r_state  <= S_SCAN;
                    end
                end
                // walk the knots, one read issued per cycle
                S_SCAN: begin
                    if (r_pv) begin
                        if (c_t <= r_x) begin
                            r_m    <= r_c;
                            r_mval <= 1'b1;
                        end
                        if ((r_c != '0) && (r_tprev < c_t)) begin
                            if (!r_firstf) begin
                                r_first  <= r_c - IW'(1);
                                r_firstf <= 1'b1;
                            end
                            r_last <= r_c - IW'(1);
                        end
                        if (r_c == r_b) begin
                            r_tb <= c_t;
                        end
                        r_tprev <= c_t;
                        if (r_c == r_n - IW'(1)) begin
                            r_state <= S_FIX;
                        end
                    end
                    if (r_i < r_n) begin
                        r_c  <= r_i;
                        r_i  <= r_i + IW'(1);
                        r_pv <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                end
                S_FIX: begin
                    if (!r_mval) begin
                        r_m <= r_first;
                    end else if (r_m == r_n - IW'(1)) begin
                        r_m <= r_last;
                    end
                    r_state <= (r_left || (r_x >= r_tb)) ? S_LRD : S_CLAMP;
                end
                S_LRD: r_state <= S_LCHK;
                // step down over knots equal to x
                S_LCHK: begin
                    if ((r_x == c_t) && (r_m >= IW'(r_k))) begin
                        r_m     <= r_m - IW'(1);
                        r_state <= S_LRD;
                    end else begin
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    r_mu <= c_mu;
                    r_a  <= '0;
                    for (int i = 1; i < ORDER_CAP; i++) begin
                        r_coef[i] <= 64'sd0;
                    end
                    if (JW'(r_nd) >= r_k) begin
                        r_coef[0] <= 64'sd0;
                        r_state   <= S_EMIT;
                    end else begin
                        r_coef[0] <= 64'sh1_0000_0000;
                        r_j       <= JW'(1);
                        r_state   <= S_JSEL;
                    end
                end
                // next recursion level
                S_JSEL: begin
                    r_a     <= '0;
                    r_saved <= 64'sd0;
                    if (r_j < r_k) begin
                        if ((r_j + JW'(r_nd)) < r_k) begin
                            r_pos   <= 1'b1;
                            r_state <= S_JRD1;
                        end else begin
                            r_pos   <= 1'b0;
                            r_state <= S_ARD1;
                        end
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_JRD1: r_state <= S_JRD2;
                S_JRD2: begin
                    r_dr[AIW'(r_j - JW'(1))] <= {c_t[31], c_t} - {r_x[31], r_x};
                    r_state <= S_JCAP;
                end
                S_JCAP: begin
                    r_dl[AIW'(r_j - JW'(1))] <= {r_x[31], r_x} - {c_t[31], c_t};
                    r_state <= S_ARD1;
                end
                S_ARD1: r_state <= S_ARD2;
                S_ARD2: begin
                    r_ta    <= c_t;
                    r_state <= S_ADEN;
                end
                S_ADEN: r_state <= S_ADIV;
                S_ADIV: begin
                    if (div_res.done) begin
                        r_term <= div_res.val;
                        if (r_pos) begin
                            r_flt   <= r_flt | div_res.flt;
                            r_state <= S_AM1S;
                        end else begin
                            r_flt        <= r_flt | div_res.flt | c_sub.flt;
                            r_coef[c_ai] <= c_sub.val;
                            r_saved      <= div_res.val;
                            if (c_alast) begin
                                r_coef[AIW'(r_j)] <= div_res.val;
                                r_j     <= r_j + JW'(1);
                                r_state <= S_JSEL;
                            end else begin
                                r_a     <= r_a + JW'(1);
                                r_state <= S_ARD1;
                            end
                        end
                    end
                end
                S_AM1S: r_state <= S_AM1;
                S_AM1: begin
                    if (mul_res.done) begin
                        r_p1    <= mul_res.val;
                        r_flt   <= r_flt | mul_res.flt;
                        r_state <= S_AM2S;
                    end
                end
                S_AM2S: r_state <= S_AM2;
                S_AM2: begin
                    if (mul_res.done) begin
                        r_flt        <= r_flt | mul_res.flt | c_add.flt;
                        r_coef[c_ai] <= c_add.val;
                        r_saved      <= mul_res.val;
                        if (c_alast) begin
                            r_coef[AIW'(r_j)] <= mul_res.val;
                            r_j     <= r_j + JW'(1);
                            r_state <= S_JSEL;
                        end else begin
                            r_a     <= r_a + JW'(1);
                            r_state <= S_ARD1;
                        end
                    end
                end
                // one result word per cycle
                S_EMIT: begin
                    r_strobe         <= 1'b1;
                    r_res.base_index <= 6'(r_mu + IW'(1) - IW'(r_k));
                    r_res.coef_slot  <= 3'(r_a);
                    r_res.coef_value <= r_coef[c_ai];
                    r_res.last       <= (r_a + JW'(1)) == r_k;
                    r_res.fault      <= r_flt;
                    if ((r_a + JW'(1)) == r_k) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_a <= r_a + JW'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = r_state != S_IDLE;
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // a burst has no gaps and ends cleanly
    a_burst_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_res.last |=> o_strobe)
        else $error("gap inside result burst");

    a_burst_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_res.last |=> !o_strobe)
        else $error("word after last of burst");

    a_slot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_res.coef_slot != 3'd0) |-> $past(o_strobe))
        else $error("burst starts at non-zero slot");

    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_load |=> !busy)
        else $error("knot load left core busy");

endmodule

// ----- src/bbe_ram.sv -----
// ---------------------------------------------------------------------------
// bbe_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module bbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/bbe_div.sv -----
// ---------------------------------------------------------------------------
// bbe_div
// Saturating quotient |c|*f*2^16/|d|, four quotient bits per cycle.
// ---------------------------------------------------------------------------
module bbe_div #(
    parameter int ORDER_CAP = bbe_pkg::ORDER_CAP_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [63:0]    i_num,
    input  logic [((ORDER_CAP > 1) ? $clog2(ORDER_CAP) : 1)-1:0] i_mult,
    input  logic signed [32:0]    i_den,
    output bbe_pkg::t_ures        o_res
);
    import bbe_pkg::*;

    localparam int MW    = (ORDER_CAP > 1) ? $clog2(ORDER_CAP) : 1;
    localparam int PW    = ((64 + MW + 16 + 3) / 4) * 4;
    localparam int STEPS = PW / 4;
    localparam int CW    = $clog2(STEPS + 1);

    logic          r_run;
    logic          r_zero;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic [33:0]   r_d;
    logic [33:0]   r_rem;
    logic [PW-1:0] r_p;
    logic [PW-1:0] r_q;
    t_ures         r_res;

    logic [33:0]   c_rem;
    logic [PW-1:0] c_p;
    logic [PW-1:0] c_q;
    logic [PW-1:0] c_load;
    t_sat          c_sat;

    // four restoring steps per cycle
    always_comb begin
        c_rem = r_rem;
        c_p   = r_p;
        c_q   = r_q;
        for (int s = 0; s < 4; s++) begin
            c_rem = {c_rem[32:0], c_p[PW-1]};
            c_p   = {c_p[PW-2:0], 1'b0};
            if (c_rem >= r_d) begin
                c_rem = c_rem - r_d;
                c_q   = {c_q[PW-2:0], 1'b1};
            end else begin
                c_q   = {c_q[PW-2:0], 1'b0};
            end
        end
    end

    assign c_load = (PW'(mag64(i_num)) * PW'(i_mult)) << 16;
    assign c_sat  = sat_pack(r_neg, |r_q[PW-1:64], r_q[63:0]);

    // sequencing of one division
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run      <= 1'b0;
            r_res.done <= 1'b0;
        end else begin
            r_res.done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_zero <= i_den == 33'sd0;
                r_neg  <= i_num[63] != i_den[32];
                r_d    <= {1'b0, (i_den[32] ? (33'd0 - i_den) : i_den)};
                r_rem  <= '0;
                r_q    <= '0;
                r_p    <= c_load;
                r_cnt  <= (i_den == 33'sd0) ? CW'(0) : CW'(STEPS);
            end else if (r_run) begin
                if (r_cnt == CW'(0)) begin
                    r_run      <= 1'b0;
                    r_res.done <= 1'b1;
                    r_res.flt  <= r_zero ? 1'b1 : c_sat.flt;
                    r_res.val  <= r_zero ? 64'sd0 : c_sat.val;
                end else begin
                    r_rem <= c_rem;
                    r_p   <= c_p;
                    r_q   <= c_q;
                    r_cnt <= r_cnt - CW'(1);
                end
            end
        end
    end

    assign o_res = r_res;

endmodule

// ----- src/bbe_mul.sv -----
// ---------------------------------------------------------------------------
// bbe_mul
// Saturating product |delta|*|term|/2^16 from two 33x32 partial products.
// ---------------------------------------------------------------------------
module bbe_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_delta,
    input  logic signed [63:0] i_term,
    output bbe_pkg::t_ures     o_res
);
    import bbe_pkg::*;

    logic [1:0]  r_ph;
    logic        r_neg;
    logic [32:0] r_ma;
    logic [63:0] r_mt;
    logic [64:0] r_pl;
    logic [64:0] r_phi;
    t_ures       r_res;

    logic [96:0] c_sum;
    t_sat        c_sat;

    assign c_sum = {r_phi, 32'd0} + {32'd0, r_pl};
    assign c_sat = sat_pack(r_neg, |c_sum[96:80], c_sum[79:16]);

    // low partial, high partial, then sum and saturate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph       <= 2'd0;
            r_res.done <= 1'b0;
        end else begin
            r_res.done <= 1'b0;
            if (i_start) begin
                r_ph  <= 2'd1;
                r_neg <= i_delta[32] != i_term[63];
                r_ma  <= i_delta[32] ? (33'd0 - i_delta) : i_delta;
                r_mt  <= mag64(i_term);
            end else begin
                case (r_ph)
                    2'd1: begin
                        r_pl <= r_ma * r_mt[31:0];
                        r_ph <= 2'd2;
                    end
                    2'd2: begin
                        r_phi <= r_ma * r_mt[63:32];
                        r_ph  <= 2'd3;
                    end
                    2'd3: begin
                        r_res.done <= 1'b1;
                        r_res.flt  <= c_sat.flt;
                        r_res.val  <= c_sat.val;
                        r_ph       <= 2'd0;
                    end
                    default: r_ph <= 2'd0;
                endcase
            end
        end
    end

    assign o_res = r_res;

endmodule

// ----- bench/tb_bspline_basis_eval_core.sv -----
// ---------------------------------------------------------------------------
// tb_bspline_basis_eval_core
// Self-checking bench for the b-spline basis core: a queue-fed driver sends
// knot loads and evaluate words, a local predictor works out every expected
// coefficient word, and a monitor checks each strobed result against it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bspline_basis_eval_core;
    import bbe_pkg::*;

    typedef enum int {E_WORD, E_CFG, E_DRAIN, E_IDLE} t_entry_kind;

    typedef struct {
        t_entry_kind kind;
        t_in         word;
        logic        idx;
        logic [5:0]  data;
        int          pct;
    } t_entry;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_in        i_in;
    logic       o_strobe;
    t_out       o_res;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [5:0] i_cfg_data;

    bspline_basis_eval_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_strobe   (o_strobe),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock, 4 ns period
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    t_entry             pending[$];
    t_out               coef_words[$];
    logic signed [31:0] knot_mirror[64];
    logic signed [31:0] gen_knots[64];
    logic [3:0]         order_r;
    logic [5:0]         bdim_r;
    bit                 run_fault;
    int                 err_count;
    int                 n_evals;
    int                 n_coefs;
    int                 n_fault_words;
    int                 idle_pct;
    int                 quiet;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        err_count++;
    endtask

    // ---------------- predictor ----------------
    function automatic longint knot_at(input int i);
        return longint'(knot_mirror[i % 64]);
    endfunction

    function automatic logic [63:0] magnitude(input longint v);
        logic [63:0] m;
        m = v;
        if (v < 0) begin
            m = 64'd0 - m;
        end
        return m;
    endfunction

    function automatic longint clip_signed(input bit neg, input logic [127:0] m);
        logic [63:0] lim;
        logic [63:0] lo;
        lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        lo  = m[63:0];
        if (m == 128'd0) begin
            return 0;
        end
        if (m[127:64] != 64'd0 || lo > lim) begin
            run_fault = 1'b1;
            lo        = lim;
        end
        return neg ? longint'(64'd0 - lo) : longint'(lo);
    endfunction

    function automatic longint knot_quotient(input longint num, input longint mult,
                                             input longint den);
        logic [127:0] p;
        if (den == 0) begin
            run_fault = 1'b1;
            return 0;
        end
        p = {64'd0, magnitude(num)} * {64'd0, mult[63:0]};
        p = p << 16;
        p = p / {64'd0, magnitude(den)};
        return clip_signed((num < 0) != (den < 0), p);
    endfunction

    function automatic longint delta_product(input longint delta, input longint term);
        logic [127:0] p;
        p = {64'd0, magnitude(delta)} * {64'd0, magnitude(term)};
        p = p >> 16;
        return clip_signed((delta < 0) != (term < 0), p);
    endfunction

    function automatic longint sum_sat(input longint a, input longint b, input bit sub);
        logic signed [64:0] s;
        s = sub ? (65'(a) - 65'(b)) : (65'(a) + 65'(b));
        if (s[64] != s[63]) begin
            run_fault = 1'b1;
            return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        return s[63:0];
    endfunction

    function automatic int knot_span(input longint x, input bit left, input int k,
                                     input int b);
        int n;
        int m;
        n = k + b;
        m = -1;
        for (int i = 0; i < n; i++) begin
            if (knot_at(i) <= x) m = i;
        end
        if (m < 0) begin
            m = 0;
            while (m < n - 1 && !(knot_at(m) < knot_at(m + 1))) m++;
        end else if (m >= n - 1) begin
            m = n - 2;
            while (m > 0 && !(knot_at(m) < knot_at(m + 1))) m--;
        end
        if (left || x >= knot_at(b)) begin
            while (x == knot_at(m) && m >= k) m--;
        end
        if (m < k - 1) m = k - 1;
        if (m > b - 1) m = b - 1;
        return m;
    endfunction

    // work out the coefficient words of one evaluate word
    task automatic predict_coefs(input t_in w);
        longint coef[8];
        longint dr[8];
        longint dl[8];
        longint x;
        longint saved;
        longint den;
        longint term;
        int     k;
        int     b;
        int     mu;
        int     nd;
        int     j;
        t_out   r;
        x  = longint'(w.param_x);
        k  = (order_r == 0) ? 1 : ((order_r > 8) ? 8 : int'(order_r));
        b  = (int'(bdim_r) < k) ? k : int'(bdim_r);
        mu = knot_span(x, w.left_continuous, k, b);
        nd = int'(w.deriv_order);
        run_fault = 1'b0;
        for (int a = 0; a < 8; a++) coef[a] = 0;
        if (nd < k) begin
            coef[0] = 64'sh1_0000_0000;
            for (j = 1; j < k - nd; j++) begin
                saved     = 0;
                dr[j - 1] = knot_at(mu + j) - x;
                dl[j - 1] = x - knot_at(mu + 1 - j);
                for (int a = 0; a < j; a++) begin
                    den     = knot_at(mu + 1 + a) - knot_at(mu + 1 - j + a);
                    term    = knot_quotient(coef[a], 1, den);
                    coef[a] = sum_sat(saved, delta_product(dr[a], term), 1'b0);
                    saved   = delta_product(dl[j - 1 - a], term);
                end
                coef[j] = saved;
            end
            for (; j < k; j++) begin
                saved = 0;
                for (int a = 0; a < j; a++) begin
                    den     = knot_at(mu + 1 + a) - knot_at(mu + 1 - j + a);
                    term    = knot_quotient(coef[a], j, den);
                    coef[a] = sum_sat(saved, term, 1'b1);
                    saved   = term;
                end
                coef[j] = saved;
            end
        end
        for (int a = 0; a < k; a++) begin
            r.base_index = 6'(mu + 1 - k);
            r.coef_slot  = 3'(a);
            r.coef_value = coef[a];
            r.last       = (a == k - 1);
            r.fault      = run_fault;
            coef_words.push_back(r);
        end
        n_evals++;
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        logic   nxt_start;
        logic   nxt_we;
        t_entry e;
        nxt_start = start;
        nxt_we    = 1'b0;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
            quiet     = 0;
        end else begin
            if (!busy && !start && coef_words.size() == 0) quiet++;
            else quiet = 0;
            // word taken at this edge
            if (start && !busy) begin
                nxt_start = 1'b0;
                if (i_in.cmd == CMD_LOAD) knot_mirror[i_in.knot_index] = i_in.knot_value;
                else predict_coefs(i_in);
            end
            if (!nxt_start && pending.size() != 0) begin
                e = pending[0];
                case (e.kind)
                    E_WORD: begin
                        if ($urandom_range(99) >= idle_pct) begin
                            void'(pending.pop_front());
                            i_in      <= e.word;
                            nxt_start = 1'b1;
                        end
                    end
                    E_CFG: begin
                        if (quiet >= 12) begin
                            void'(pending.pop_front());
                            i_cfg_idx  <= e.idx;
                            i_cfg_data <= e.data;
                            nxt_we     = 1'b1;
                            if (e.idx == CFG_ORDER) order_r = e.data[3:0];
                            else bdim_r = e.data;
                        end
                    end
                    E_DRAIN: begin
                        if (coef_words.size() == 0) void'(pending.pop_front());
                    end
                    default: begin
                        idle_pct = e.pct;
                        void'(pending.pop_front());
                    end
                endcase
            end
        end
        start    <= nxt_start;
        i_cfg_we <= nxt_we;
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_out x;
        if (i_rst_n && o_strobe) begin
            if (coef_words.size() == 0) begin
                report($sformatf("unexpected result word %h", o_res));
            end else begin
                x = coef_words.pop_front();
                n_coefs++;
                if (x.fault) n_fault_words++;
                if (o_res.base_index !== x.base_index)
                    report($sformatf("base_index %0d, want %0d", o_res.base_index,
                                     x.base_index));
                if (o_res.coef_slot !== x.coef_slot)
                    report($sformatf("coef_slot %0d, want %0d", o_res.coef_slot,
                                     x.coef_slot));
                if (o_res.coef_value !== x.coef_value)
                    report($sformatf("slot %0d coef_value %h, want %h", x.coef_slot,
                                     o_res.coef_value, x.coef_value));
                if (o_res.last !== x.last)
                    report($sformatf("slot %0d last %b, want %b", x.coef_slot,
                                     o_res.last, x.last));
                if (o_res.fault !== x.fault)
                    report($sformatf("slot %0d fault %b, want %b", x.coef_slot,
                                     o_res.fault, x.fault));
            end
        end
    end

    // ---------------- stimulus helpers ----------------
    function automatic t_in blank_word();
        t_in w;
        w.cmd             = CMD_EVAL;
        w.knot_index      = 6'($urandom);
        w.knot_value      = 32'($urandom);
        w.param_x         = 32'($urandom);
        w.deriv_order     = 4'($urandom);
        w.left_continuous = 1'($urandom);
        return w;
    endfunction

    task automatic push_word(input t_in w);
        t_entry e;
        e.kind = E_WORD;
        e.word = w;
        pending.push_back(e);
    endtask

    task automatic push_load(input int idx, input logic signed [31:0] v);
        t_in w;
        w            = blank_word();
        w.cmd        = CMD_LOAD;
        w.knot_index = 6'(idx);
        w.knot_value = v;
        gen_knots[idx % 64] = v;
        push_word(w);
    endtask

    task automatic push_eval(input logic signed [31:0] x, input logic [3:0] d,
                             input logic left);
        t_in w;
        w                 = blank_word();
        w.cmd             = CMD_EVAL;
        w.param_x         = x;
        w.deriv_order     = d;
        w.left_continuous = left;
        push_word(w);
    endtask

    task automatic push_ctl(input t_entry_kind kind, input logic idx,
                            input logic [5:0] data, input int pct);
        t_entry e;
        e.kind = kind;
        e.idx  = idx;
        e.data = data;
        e.pct  = pct;
        pending.push_back(e);
    endtask

    task automatic push_setting(input logic [3:0] ord, input logic [5:0] bd);
        push_ctl(E_CFG, CFG_ORDER, {2'b00, ord}, 0);
        push_ctl(E_CFG, CFG_BDIM, bd, 0);
    endtask

    // leading knots of the table: 0 ascending with repeats, 1 noise, 2 wide ascending
    task automatic load_table(input int mode, input int cnt);
        longint v;
        longint stp;
        v = (mode == 2) ? -64'sd2147483648 + $urandom_range(65535)
                        : longint'($urandom_range(8)) * 65536 - 262144;
        for (int i = 0; i < cnt; i++) begin
            if (mode == 1) begin
                push_load(i, $urandom);
            end else begin
                stp = ($urandom_range(99) < 25) ? 0 :
                      (mode == 2) ? longint'($urandom_range(32'h0800_0000))
                                  : longint'($urandom_range(32'h0003_0000)) + 1;
                if (i != 0) v = v + stp;
                if (v > 2147483647) v = 2147483647;
                push_load(i, 32'(v));
            end
        end
    endtask

    task automatic random_eval(input int cnt);
        longint x;
        int     sel;
        sel = $urandom_range(99);
        x   = longint'(gen_knots[$urandom_range(cnt - 1)]);
        if (sel < 55) x = x + $urandom_range(65536) - 32768;
        else if (sel >= 80) x = longint'(signed'(32'($urandom)));
        if (x > 2147483647) x = 2147483647;
        if (x < -2147483648) x = -2147483648;
        push_eval(32'(x), ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                    : 4'($urandom_range(8)),
                  1'($urandom_range(1)));
    endtask

    // ---------------- sequence ----------------
    initial begin
        int phase;
        int kk;
        int bb;
        int cnt;
        logic [3:0] ord_set[10] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd2, 4'd6,
                                    4'd8, 4'd5, 4'd4};
        logic [5:0] bd_set[10]  = '{6'd1, 6'd63, 6'd5, 6'd20, 6'd0, 6'd10, 6'd12,
                                    6'd8, 6'd30, 6'd40};
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_in       = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_ORDER;
        i_cfg_data = '0;
        order_r    = ORDER_RST;
        bdim_r     = BDIM_RST;
        idle_pct   = 0;
        err_count  = 0;
        n_evals    = 0;
        n_coefs    = 0;
        n_fault_words = 0;
        for (int i = 0; i < 64; i++) knot_mirror[i] = '0;

        // directed part at reset setting: knots 0 to 4 at zero, the rest evenly spaced
        push_ctl(E_IDLE, 1'b0, 6'd0, 20);
        for (int i = 0; i < 64; i++)
            push_load(i, (i < 4) ? 32'sd0 : (i == 5) ? 32'sh0001_0000 :
                         32'((i - 4) * 65536));
        push_eval(32'sh8000_0000, 4'd0, 1'b0);
        push_eval(32'sh7FFF_FFFF, 4'd0, 1'b1);
        push_eval(32'sh0001_0000, 4'd0, 1'b0);
        push_eval(32'sh0001_0000, 4'd0, 1'b1);
        push_eval(32'sh0000_8000, 4'd1, 1'b0);
        push_eval(32'sh0000_8000, 4'd2, 1'b1);
        push_eval(32'sh0000_8000, 4'd3, 1'b0);
        push_eval(32'sh0000_8000, 4'd4, 1'b0);
        push_eval(32'sh0000_8000, 4'd15, 1'b1);
        push_eval(32'sh0000_0000, 4'd0, 1'b1);
        push_eval(32'sh0000_0000, 4'd0, 1'b0);
        push_ctl(E_DRAIN, 1'b0, 6'd0, 0);
        // huge spread to drive saturation
        push_load(4, 32'sh7FFF_0000);
        push_load(5, 32'sh7FFF_FFFF);
        push_eval(32'sh8000_0000, 4'd1, 1'b0);
        push_eval(32'sh7FFF_8000, 4'd0, 1'b0);
        push_eval(32'sh7FFF_8000, 4'd3, 1'b1);

        // random phases over several settings, reloading the knots in use plus occasional random loads
        for (phase = 0; phase < 10; phase++) begin
            kk  = (ord_set[phase] == 0) ? 1 :
                  (ord_set[phase] > 8) ? 8 : int'(ord_set[phase]);
            bb  = (int'(bd_set[phase]) < kk) ? kk : int'(bd_set[phase]);
            cnt = (kk + bb > 64) ? 64 : kk + bb;
            if (phase == 3) push_ctl(E_IDLE, 1'b0, 6'd0, 69);
            if (phase == 7) push_ctl(E_IDLE, 1'b0, 6'd0, 0);
            push_ctl(E_DRAIN, 1'b0, 6'd0, 0);
            push_setting(ord_set[phase], bd_set[phase]);
            load_table((phase % 4 == 1) ? 1 : (phase % 4 == 3) ? 2 : 0, cnt);
            for (int i = 0; i < 15; i++) begin
                if (i == 7) push_ctl(E_DRAIN, 1'b0, 6'd0, 0);
                if ($urandom_range(19) == 0)
                    push_load($urandom_range(63), $urandom);
                random_eval(cnt);
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending.size() != 0 || start || coef_words.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d evaluate words, %0d coefficient words (%0d flagged)",
                 n_evals, n_coefs, n_fault_words);
        $display("orders 0 to 15 and bdim 0 to 63 among the settings, loads throughout");
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // run time limit
    initial begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
